[sv/nugs_pkg.sv]
// package: widths, register map, reset values and config struct of the gradient sum unit
`default_nettype none

package nugs_pkg;

    // payload widths
    localparam int GRAD_W = 32;
    localparam int SUM_W  = 38;

    // parameter defaults
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_SCALE = 8;

    // fixed height range and row counter width
    localparam int HEIGHT_LIMIT = 4096;
    localparam int ROW_W        = 12;

    // raw register widths
    localparam int SCALE_RAW_W  = 4;
    localparam int WIDTH_RAW_W  = 11;
    localparam int HEIGHT_RAW_W = 13;

    // clamped value widths, wide enough for the whole parameter range
    localparam int SCALE_EFF_W  = 5;
    localparam int WIDTH_EFF_W  = 14;
    localparam int HEIGHT_EFF_W = 13;

    // register reset values
    localparam logic [SCALE_RAW_W-1:0]  SCALE_RST  = 4'd2;
    localparam logic [WIDTH_RAW_W-1:0]  WIDTH_RST  = 11'd1024;
    localparam logic [HEIGHT_RAW_W-1:0] HEIGHT_RST = 13'd1024;

    // apb port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_SCALE  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } nugs_reg_t;

    // clamped configuration and restart strobe
    typedef struct packed {
        logic [SCALE_EFF_W-1:0]  scale;
        logic [WIDTH_EFF_W-1:0]  width;
        logic [HEIGHT_EFF_W-1:0] height;
        logic                    restart;
    } nugs_cfg_t;

endpackage

`default_nettype wire

[sv/nugs_if.sv]
// interfaces: gradient input channel and block sum output channel
`default_nettype none

interface nugs_grad_if
    import nugs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [GRAD_W-1:0] grad;

    modport source (output valid, output grad, input ready);
    modport sink (input valid, input grad, output ready);
endinterface

interface nugs_sum_if
    import nugs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] block_sum;
    logic             row_end;
    logic             plane_end;

    modport source (output valid, output block_sum, output row_end, output plane_end,
                    input ready);
    modport sink (input valid, input block_sum, input row_end, input plane_end,
                  output ready);
endinterface

`default_nettype wire

[sv/nugs_cfg_regs.sv]
// apb register file with range clamping of scale, width and height
`default_nettype none

module nugs_cfg_regs
    import nugs_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_SCALE = DEF_MAX_SCALE
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output nugs_cfg_t                  cfg
);

    logic [SCALE_RAW_W-1:0]  scale_reg;
    logic [WIDTH_RAW_W-1:0]  width_reg;
    logic [HEIGHT_RAW_W-1:0] height_reg;
    logic                    wr_en;
    logic                    hit;
    nugs_reg_t               idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = nugs_reg_t'(paddr[3:2]);

    // address decode
    always_comb
    begin
        unique case (idx)
            REG_SCALE:  hit = 1'b1;
            REG_WIDTH:  hit = 1'b1;
            REG_HEIGHT: hit = 1'b1;
            default:    hit = 1'b0;
        endcase
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SCALE:  scale_reg  <= pwdata[SCALE_RAW_W-1:0];
                REG_WIDTH:  width_reg  <= pwdata[WIDTH_RAW_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[HEIGHT_RAW_W-1:0];
                default:    ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_SCALE:  prdata = APB_DATA_W'(scale_reg);
            REG_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // clamp to the usable ranges
    always_comb
    begin
        priority if (scale_reg == '0)
            cfg.scale = SCALE_EFF_W'(1);
        else if (32'(scale_reg) > 32'(MAX_SCALE))
            cfg.scale = SCALE_EFF_W'(MAX_SCALE);
        else
            cfg.scale = SCALE_EFF_W'(scale_reg);

        priority if (width_reg == '0)
            cfg.width = WIDTH_EFF_W'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            cfg.width = WIDTH_EFF_W'(MAX_WIDTH);
        else
            cfg.width = WIDTH_EFF_W'(width_reg);

        priority if (height_reg == '0)
            cfg.height = HEIGHT_EFF_W'(1);
        else if (32'(height_reg) > 32'(HEIGHT_LIMIT))
            cfg.height = HEIGHT_EFF_W'(HEIGHT_LIMIT);
        else
            cfg.height = height_reg;

        cfg.restart = wr_en && hit;
    end

endmodule

`default_nettype wire

[sv/nearest_upsample_gradient_sum_unit.sv]
// top level: block position counters, row sum memory with read-modify-write, output register
//
// Backward pass of integer nearest upsampling: gradient samples of the large
// plane come in raster order, one per item, and every scale x scale block is
// summed into one exact 38-bit value, emitted on the block's last sample with
// row_end and plane_end marks. The unit takes one item per clock cycle unless
// the output stalls; a sum passes the read-modify-write stage and output register.
// Running block sums of the current output row live in a MAX_WIDTH-entry
// memory with one write port and one registered read port; a read is issued
// when an item is taken and the add and write-back happen when the stage moves on,
// with the freshly written sum forwarded when the next item hits the same
// entry. The output register lets a new item enter while a sum waits to be
// taken. Any write to a known register restarts the stream at the top left of
// a plane; write registers only while the unit is idle. No clearing pass is
// needed after reset: the first sample of every block overwrites its entry.
`default_nettype none

module nearest_upsample_gradient_sum_unit
    import nugs_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_SCALE = DEF_MAX_SCALE
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    nugs_grad_if.sink                  grad_in,
    nugs_sum_if.source                 sum_out
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int SUB_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int SF_W  = $clog2(MAX_SCALE + 1);

    nugs_cfg_t cfg;

    logic [SF_W-1:0]         sf_eff;
    logic [WID_W-1:0]        w_eff;
    logic [HEIGHT_EFF_W-1:0] h_eff;

    // position counters
    logic [COL_W-1:0] col_reg, col_next;
    logic [SUB_W-1:0] sub_col_reg, sub_col_next;
    logic [SUB_W-1:0] sub_row_reg, sub_row_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [WID_W-1:0]        col_inc;
    logic [SF_W-1:0]         sub_col_inc;
    logic [SF_W-1:0]         sub_row_inc;
    logic [HEIGHT_EFF_W-1:0] row_inc;
    logic                    col_wrap;
    logic                    sub_col_wrap;
    logic                    sub_row_wrap;

    logic in_first;
    logic in_last;
    logic in_rend;
    logic in_pend;
    logic accept;

    // read-modify-write stage
    logic              s1_valid_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;
    logic              s1_rend_reg;
    logic              s1_pend_reg;
    logic              s1_fwd_reg;
    logic [GRAD_W-1:0] s1_grad_reg;
    logic [SUM_W-1:0]  fwd_data_reg;
    logic [SUM_W-1:0]  rdata_reg;
    logic [SUM_W-1:0]  grad_ext;
    logic [SUM_W-1:0]  base;
    logic [SUM_W-1:0]  acc;
    logic              s1_fire;

    // output register
    logic             out_valid_reg;
    logic [SUM_W-1:0] out_sum_reg;
    logic             out_rend_reg;
    logic             out_pend_reg;

    logic [SUM_W-1:0] row_mem [MAX_WIDTH];

    nugs_cfg_regs #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;
    assign sf_eff = SF_W'(cfg.scale);
    assign w_eff  = WID_W'(cfg.width);
    assign h_eff  = cfg.height;

    // handshake
    assign s1_fire       = s1_valid_reg && (!s1_last_reg || !out_valid_reg || sum_out.ready);
    assign grad_in.ready = !s1_valid_reg || s1_fire;
    assign accept        = grad_in.valid && grad_in.ready;

    // block position of the incoming item and counter advance
    always_comb
    begin
        col_inc      = WID_W'(col_reg) + WID_W'(1);
        sub_col_inc  = SF_W'(sub_col_reg) + SF_W'(1);
        sub_row_inc  = SF_W'(sub_row_reg) + SF_W'(1);
        row_inc      = HEIGHT_EFF_W'(row_reg) + HEIGHT_EFF_W'(1);
        sub_col_wrap = sub_col_inc >= sf_eff;
        sub_row_wrap = sub_row_inc >= sf_eff;
        col_wrap     = col_inc >= w_eff;

        in_first = (sub_col_reg == '0) && (sub_row_reg == '0);
        in_last  = sub_col_wrap && sub_row_wrap;
        in_rend  = col_wrap;
        in_pend  = col_wrap && (row_inc >= h_eff);

        col_next     = col_reg;
        sub_col_next = sub_col_reg;
        sub_row_next = sub_row_reg;
        row_next     = row_reg;

        if (!sub_col_wrap)
        begin
            sub_col_next = SUB_W'(sub_col_inc);
        end
        else
        begin
            sub_col_next = '0;
            if (!col_wrap)
            begin
                col_next = COL_W'(col_inc);
            end
            else
            begin
                col_next = '0;
                if (!sub_row_wrap)
                begin
                    sub_row_next = SUB_W'(sub_row_inc);
                end
                else
                begin
                    sub_row_next = '0;
                    if (row_inc >= h_eff)
                        row_next = '0;
                    else
                        row_next = ROW_W'(row_inc);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            row_reg     <= '0;
        end
        else if (cfg.restart)
        begin
            col_reg     <= '0;
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            row_reg     <= '0;
        end
        else if (accept)
        begin
            col_reg     <= col_next;
            sub_col_reg <= sub_col_next;
            sub_row_reg <= sub_row_next;
            row_reg     <= row_next;
        end
    end

    // row sum memory: read on accept, write back when the stage moves on
    always_ff @(posedge clk)
    begin
        if (s1_fire)
            row_mem[s1_col_reg] <= acc;
        if (accept)
            rdata_reg <= row_mem[col_reg];
    end

    // add the sample to the running sum, forwarded value when the entry was just written
    always_comb
    begin
        grad_ext = {{(SUM_W - GRAD_W){s1_grad_reg[GRAD_W-1]}}, s1_grad_reg};
        base     = s1_fwd_reg ? fwd_data_reg : rdata_reg;
        acc      = s1_first_reg ? grad_ext : base + grad_ext;
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= col_reg;
            s1_first_reg <= in_first;
            s1_last_reg  <= in_last;
            s1_rend_reg  <= in_rend;
            s1_pend_reg  <= in_pend;
            s1_grad_reg  <= grad_in.grad;
            s1_fwd_reg   <= s1_fire && (s1_col_reg == col_reg);
        end
        if (s1_fire)
            fwd_data_reg <= acc;
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (sum_out.ready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            out_sum_reg  <= acc;
            out_rend_reg <= s1_rend_reg;
            out_pend_reg <= s1_pend_reg;
        end
    end

    assign sum_out.valid     = out_valid_reg;
    assign sum_out.block_sum = out_sum_reg;
    assign sum_out.row_end   = out_rend_reg;
    assign sum_out.plane_end = out_pend_reg;

    // checks
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        WID_W'(col_reg) < w_eff)
        else $error("column counter beyond plane width");

    a_sub_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SF_W'(sub_col_reg) < sf_eff) && (SF_W'(sub_row_reg) < sf_eff))
        else $error("sub-block counter beyond scale factor");

    a_plane_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_pend_reg |-> out_rend_reg)
        else $error("plane end without row end");

    a_no_result_loss: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |-> !out_valid_reg || sum_out.ready)
        else $error("result written over a waiting sum");

endmodule

`default_nettype wire

[dv/tb_nearest_upsample_gradient_sum_unit.sv]
// testbench: gradient sum unit driven with block rasters, sums checked against a predictor
`timescale 1ns / 1ps

module tb_nearest_upsample_gradient_sum_unit;
    import nugs_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 1600;
    localparam logic [1:0] UNMAPPED_REG = 2'd3;

    // how gradient values of one random phase are drawn
    typedef enum {
        GRAD_MAX_HEAVY,
        GRAD_MIN_HEAVY,
        GRAD_MIXED
    } grad_mix_t;

    typedef struct packed {
        logic [SUM_W-1:0] block_sum;
        logic             row_end;
        logic             plane_end;
    } block_sum_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    nugs_grad_if grad_if ();
    nugs_sum_if  sum_if ();

    nearest_upsample_gradient_sum_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .grad_in (grad_if),
        .sum_out (sum_if)
    );

    always #4 clk = ~clk;

    // predictor copy of the registers and the stream position
    logic [SCALE_RAW_W-1:0]  cfg_scale  = SCALE_RST;
    logic [WIDTH_RAW_W-1:0]  cfg_width  = WIDTH_RST;
    logic [HEIGHT_RAW_W-1:0] cfg_height = HEIGHT_RST;
    int pos_col     = 0;
    int pos_sub_col = 0;
    int pos_sub_row = 0;
    int pos_row     = 0;
    logic [SUM_W-1:0] row_acc [DEF_MAX_WIDTH];

    block_sum_t pending_sums [$];
    int  err_count     = 0;
    int  idle_cycles   = 0;
    bit  quiet_stretch = 1'b0;

    function automatic int clamp_cfg(input int v, input int hi);
        if (v < 1)
        begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    // running block sums, one expected item on the last sample of a block
    function automatic void predict_block_sum(input logic [GRAD_W-1:0] g);
        int sf;
        int w;
        int h;
        logic [SUM_W-1:0] ext;
        logic [SUM_W-1:0] acc;
        block_sum_t r;
        sf  = clamp_cfg(int'(cfg_scale), DEF_MAX_SCALE);
        w   = clamp_cfg(int'(cfg_width), DEF_MAX_WIDTH);
        h   = clamp_cfg(int'(cfg_height), HEIGHT_LIMIT);
        ext = {{(SUM_W-GRAD_W){g[GRAD_W-1]}}, g};
        if (pos_sub_row == 0 && pos_sub_col == 0)
        begin
            acc = ext;
        end
        else
        begin
            acc = row_acc[pos_col] + ext;
        end
        row_acc[pos_col] = acc;
        if (pos_sub_col + 1 >= sf && pos_sub_row + 1 >= sf)
        begin
            r.block_sum = acc;
            r.row_end   = (pos_col + 1 >= w);
            r.plane_end = r.row_end && (pos_row + 1 >= h);
            pending_sums.insert(pending_sums.size(), r);
        end
        // advance the raster position
        pos_sub_col++;
        if (pos_sub_col >= sf)
        begin
            pos_sub_col = 0;
            pos_col++;
            if (pos_col >= w)
            begin
                pos_col = 0;
                pos_sub_row++;
                if (pos_sub_row >= sf)
                begin
                    pos_sub_row = 0;
                    pos_row++;
                    if (pos_row >= h)
                    begin
                        pos_row = 0;
                    end
                end
            end
        end
    endfunction

    // random bits above the register field
    function automatic logic [31:0] with_noise(input logic [31:0] raw, input int bits);
        logic [31:0] m;
        m = (32'd1 << bits) - 32'd1;
        return ($urandom & ~m) | (raw & m);
    endfunction

    function automatic logic [GRAD_W-1:0] rand_grad(input grad_mix_t mix);
        case (mix)
            GRAD_MAX_HEAVY: return ($urandom_range(3) != 0) ? 32'h7FFF_FFFF : $urandom;
            GRAD_MIN_HEAVY: return ($urandom_range(3) != 0) ? 32'h8000_0000 : $urandom;
            default:
            begin
                case ($urandom_range(7))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return $urandom_range(0, 511);
                    3: return -$urandom_range(1, 512);
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // one gradient item, with random idle cycles ahead of it
    task automatic send_grad(input logic [GRAD_W-1:0] g);
        while (!quiet_stretch && $urandom_range(99) < 8)
        begin
            grad_if.valid <= 1'b0;
            @(posedge clk);
        end
        grad_if.valid <= 1'b1;
        grad_if.grad  <= g;
        do
            @(posedge clk);
        while (grad_if.ready !== 1'b1);
        predict_block_sum(g);
    endtask

    // drain all expected sums, then let in-flight samples be written back
    task automatic settle_unit();
        grad_if.valid <= 1'b0;
        while (pending_sums.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        bit known;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        // mirror the write, a known register restarts the raster
        known = 1'b1;
        case (idx)
            REG_SCALE:  cfg_scale  = data[SCALE_RAW_W-1:0];
            REG_WIDTH:  cfg_width  = data[WIDTH_RAW_W-1:0];
            REG_HEIGHT: cfg_height = data[HEIGHT_RAW_W-1:0];
            default:    known = 1'b0;
        endcase
        if (known)
        begin
            pos_col     = 0;
            pos_sub_col = 0;
            pos_sub_row = 0;
            pos_row     = 0;
        end
        @(posedge clk);
    endtask

    task automatic read_check(input logic [1:0] idx, input logic [31:0] want);
        logic [APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== want)
        begin
            $error("register %0d expected %0d actual %0d", idx, want, got);
            err_count++;
        end
    endtask

    // write all three registers and read them back
    task automatic configure(input logic [31:0] s, input logic [31:0] w, input logic [31:0] h);
        write_reg(REG_SCALE, s);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        read_check(REG_SCALE, 32'(s[SCALE_RAW_W-1:0]));
        read_check(REG_WIDTH, 32'(w[WIDTH_RAW_W-1:0]));
        read_check(REG_HEIGHT, 32'(h[HEIGHT_RAW_W-1:0]));
    endtask

    // register values out of reset, then a few samples on the default geometry
    task automatic test_reset_values();
        read_check(REG_SCALE, 32'(SCALE_RST));
        read_check(REG_WIDTH, 32'(WIDTH_RST));
        read_check(REG_HEIGHT, 32'(HEIGHT_RST));
        send_grad(32'h0001_0000);
        send_grad(32'hFFFF_0000);
        send_grad(32'h7FFF_FFFF);
        settle_unit();
    endtask

    // scale one passes samples through, extremes and both marks
    task automatic test_unit_scale_extremes();
        configure(1, 3, 2);
        send_grad(32'h7FFF_FFFF);
        send_grad(32'h8000_0000);
        send_grad(32'h0000_0000);
        send_grad(32'hFFFF_FFFF);
        send_grad(32'h0000_0001);
        send_grad(32'h5555_AAAA);
        settle_unit();
    endtask

    // zero scale, width and height clamp to one; upper data bits ignored
    task automatic test_degenerate_sizes();
        configure(32'hFFFF_FFF0, 32'hFFFF_F800, 32'hFFFF_E000);
        send_grad(32'hAAAA_5555);
        send_grad(32'h8000_0001);
        settle_unit();
    endtask

    // rewriting a register with its own value drops a half-built block
    task automatic test_restart_on_write();
        configure(2, 1, 1);
        send_grad(32'h1234_5678);
        send_grad(32'h7FFF_FFFF);
        send_grad(32'h0F0F_0F0F);
        settle_unit();
        write_reg(REG_SCALE, 2);
        send_grad(32'h0000_0010);
        send_grad(32'hFFFF_FFF0);
        send_grad(32'h7FFF_FFFF);
        send_grad(32'h7FFF_FFFF);
        settle_unit();
    endtask

    // a write outside the register map keeps the raster position
    task automatic test_unmapped_write();
        configure(1, 2, 2);
        send_grad(32'h0000_0003);
        settle_unit();
        write_reg(UNMAPPED_REG, $urandom);
        send_grad(32'h8000_0000);
        send_grad(32'h0000_0007);
        send_grad(32'hC000_0000);
        settle_unit();
    endtask

    // random geometries, mostly whole planes, some cut short
    task automatic test_random_planes();
        int sf;
        int w;
        int h;
        int total;
        int rand_sent;
        logic [31:0] s_raw;
        logic [31:0] w_raw;
        logic [31:0] h_raw;
        grad_mix_t mix;
        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            // pick the effective geometry
            sf = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(5, 8);
            w  = $urandom_range(1, 12);
            h  = $urandom_range(1, 4);
            if ($urandom_range(99) < 10)
            begin
                w  = $urandom_range(1) ? DEF_MAX_WIDTH : $urandom_range(200, DEF_MAX_WIDTH);
                sf = 1;
                h  = $urandom_range(1, 2);
            end
            else if ($urandom_range(99) < 4)
            begin
                w  = $urandom_range(1, 3);
                sf = 1;
                h  = HEIGHT_LIMIT;
            end
            total = w * h * sf * sf * $urandom_range(1, 3);
            if ($urandom_range(99) < 30)
            begin
                total = $urandom_range(1, total);
            end
            if (total > 1100)
            begin
                total = 1100;
            end
            if (total > RANDOM_ITEMS - rand_sent)
            begin
                total = RANDOM_ITEMS - rand_sent;
            end
            // encode, sometimes through an out of range alias
            s_raw = sf;
            w_raw = w;
            h_raw = h;
            if (sf == 1 && $urandom_range(1))
            begin
                s_raw = 0;
            end
            if (sf == DEF_MAX_SCALE && $urandom_range(1))
            begin
                s_raw = $urandom_range(DEF_MAX_SCALE + 1, 15);
            end
            if (w == 1 && $urandom_range(1))
            begin
                w_raw = 0;
            end
            if (w == DEF_MAX_WIDTH && $urandom_range(1))
            begin
                w_raw = $urandom_range(DEF_MAX_WIDTH + 1, 2047);
            end
            if (h == 1 && $urandom_range(1))
            begin
                h_raw = 0;
            end
            if (h == HEIGHT_LIMIT && $urandom_range(1))
            begin
                h_raw = $urandom_range(HEIGHT_LIMIT + 1, 8191);
            end
            configure(with_noise(s_raw, SCALE_RAW_W), with_noise(w_raw, WIDTH_RAW_W),
                      with_noise(h_raw, HEIGHT_RAW_W));
            case ($urandom_range(3))
                0: mix = GRAD_MAX_HEAVY;
                1: mix = GRAD_MIN_HEAVY;
                default: mix = GRAD_MIXED;
            endcase
            for (int i = 0; i < total; i++)
            begin
                quiet_stretch = (rand_sent >= 600 && rand_sent < 900);
                send_grad(rand_grad(mix));
                rand_sent++;
            end
            quiet_stretch = 1'b0;
            settle_unit();
        end
    endtask

    // output side stalls at random
    always @(posedge clk)
    begin
        sum_if.ready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= 8);
    end

    // compare each accepted sum with the oldest expected one
    always @(posedge clk)
    begin
        block_sum_t want;
        if (rst_n === 1'b1 && sum_if.valid === 1'b1 && sum_if.ready === 1'b1)
        begin
            if (pending_sums.size() == 0)
            begin
                $error("unexpected block sum %0d", $signed(sum_if.block_sum));
                err_count++;
            end
            else
            begin
                want = pending_sums.pop_front();
                if (sum_if.block_sum !== want.block_sum)
                begin
                    $error("block_sum expected %0d actual %0d",
                           $signed(want.block_sum), $signed(sum_if.block_sum));
                    err_count++;
                end
                if (sum_if.row_end !== want.row_end)
                begin
                    $error("row_end expected %0d actual %0d", want.row_end, sum_if.row_end);
                    err_count++;
                end
                if (sum_if.plane_end !== want.plane_end)
                begin
                    $error("plane_end expected %0d actual %0d", want.plane_end,
                           sum_if.plane_end);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((grad_if.valid === 1'b1 && grad_if.ready === 1'b1) ||
            (sum_if.valid === 1'b1 && sum_if.ready === 1'b1) ||
            (psel === 1'b1 && penable === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("nearest_upsample_gradient_sum_unit verification failed");
            $finish;
        end
    end

    // reset, tests in turn, final verdict
    initial
    begin
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        grad_if.valid <= 1'b0;
        grad_if.grad  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_unit_scale_extremes();
        test_degenerate_sizes();
        test_restart_on_write();
        test_unmapped_write();
        test_random_planes();

        settle_unit();
        if (err_count == 0)
        begin
            $display("nearest_upsample_gradient_sum_unit verification clean");
        end
        else
        begin
            $display("nearest_upsample_gradient_sum_unit verification failed");
        end
        $finish;
    end

endmodule
